/* hdl/dsbd_pkg.sv */
// Shared constants, step tables and calendar functions for the date shifter.
package dsbd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned GAP_W   = 22;
    localparam int unsigned NUM_W   = 22;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned QBITS_W = 14;

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [GAP_W-1:0]   GAP_LIMIT  = 22'd3649270;
    localparam logic [NUM_W:0]     TOTAL_DAYS = 23'd3652059;
    localparam logic [STEP_W-1:0]  LAST_STEP  = 4'd13;
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic             ge;
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] acc;
    } t_unit_res;

    function automatic logic [NUM_W-1:0] step_years(input logic [STEP_W-1:0] s);
        case (s)
            4'd0:    step_years = 22'd6400;
            4'd1:    step_years = 22'd3200;
            4'd2:    step_years = 22'd1600;
            4'd3:    step_years = 22'd800;
            4'd4:    step_years = 22'd400;
            4'd5:    step_years = 22'd200;
            4'd6:    step_years = 22'd100;
            4'd7:    step_years = 22'd64;
            4'd8:    step_years = 22'd32;
            4'd9:    step_years = 22'd16;
            4'd10:   step_years = 22'd8;
            4'd11:   step_years = 22'd4;
            4'd12:   step_years = 22'd2;
            4'd13:   step_years = 22'd1;
            default: step_years = 22'd0;
        endcase
    endfunction

    function automatic logic [NUM_W-1:0] step_days(input logic [STEP_W-1:0] s);
        case (s)
            4'd0:    step_days = 22'd2337552;
            4'd1:    step_days = 22'd1168776;
            4'd2:    step_days = 22'd584388;
            4'd3:    step_days = 22'd292194;
            4'd4:    step_days = 22'd146097;
            4'd5:    step_days = 22'd73048;
            4'd6:    step_days = 22'd36524;
            4'd7:    step_days = 22'd23376;
            4'd8:    step_days = 22'd11688;
            4'd9:    step_days = 22'd5844;
            4'd10:   step_days = 22'd2922;
            4'd11:   step_days = 22'd1461;
            4'd12:   step_days = 22'd730;
            4'd13:   step_days = 22'd365;
            default: step_days = 22'd0;
        endcase
    endfunction

    // quotient bits: [13:9] 400s, [8:7] 100s, [6:2] 4s, [1:0] single years of (year - 1)
    function automatic logic leap_of(input logic [QBITS_W-1:0] q);
        leap_of = (q[1:0] == 2'd3) && ((q[6:2] != 5'd24) || (q[8:7] == 2'd3));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        case (m)
            4'd2:                      month_days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
            default:                   month_days = 5'd31;
        endcase
    endfunction

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        case (m)
            4'd2:    days_before_month = 9'd31;
            4'd3:    days_before_month = 9'd59;
            4'd4:    days_before_month = 9'd90;
            4'd5:    days_before_month = 9'd120;
            4'd6:    days_before_month = 9'd151;
            4'd7:    days_before_month = 9'd181;
            4'd8:    days_before_month = 9'd212;
            4'd9:    days_before_month = 9'd243;
            4'd10:   days_before_month = 9'd273;
            4'd11:   days_before_month = 9'd304;
            4'd12:   days_before_month = 9'd334;
            default: days_before_month = 9'd0;
        endcase
    endfunction

endpackage

/* hdl/dsbd_unit.sv */
// Shared compare, subtract and accumulate step used by the year, day-number and month-walk phases.
module dsbd_unit (
    input  logic [dsbd_pkg::NUM_W-1:0] i_rem,
    input  logic [dsbd_pkg::NUM_W-1:0] i_acc,
    input  logic [dsbd_pkg::NUM_W-1:0] i_cmp,
    input  logic [dsbd_pkg::NUM_W-1:0] i_wgt,
    output dsbd_pkg::t_unit_res        o_res
);

    always_comb begin
        o_res.ge  = (i_rem >= i_cmp);
        o_res.rem = o_res.ge ? (i_rem - i_cmp) : i_rem;
        o_res.acc = o_res.ge ? (i_acc + i_wgt) : i_acc;
    end

endmodule

/* hdl/date_shift_by_days.sv */
// Top level: Gregorian date shift by a day count in either direction, iterative datapath.
//
// Channel  | Dir | Signals                  | Payload
// slave    | in  | tvalid tready tdata tuser| date, gap days, direction
// master   | out | tvalid tready tdata tuser| result date, status
//
// An item runs to its result before the next is accepted: 14 steps turn the year into a
// day number, one adds month and day, one shifts, 14 steps turn the day number back into a
// year, and 1 to 12 steps walk the months; the year, day-number and month-walk steps share
// one compare-subtract-accumulate unit.
// A bad year, month or gap answers in the cycle after acceptance; a bad day or a zero
// gap answers after the year steps, a full shift after the month walk.
// The slave side is ready only when idle; a result holds until taken.
// Reset is synchronous, active low, and clears the sequencer only.
module date_shift_by_days (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // start_year[13:0] start_month[17:14] start_day[22:18]
                                    // gap_days[44:23] zero[47:45]
    input  logic        i_s_tuser,  // action[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // result_year[13:0] result_month[17:14]
                                    // result_day[22:18] zero[23]
    output logic [1:0]  o_m_tuser   // status[1:0]
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_YSTEP = 3'd1;
    localparam logic [2:0] S_MDAY  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_NSTEP = 3'd4;
    localparam logic [2:0] S_MWALK = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                      r_state, n_state;
    logic                            r_back, n_back;
    logic [dsbd_pkg::MONTH_W-1:0]    r_m, n_m;
    logic [dsbd_pkg::DAY_W-1:0]      r_d, n_d;
    logic [dsbd_pkg::GAP_W-1:0]      r_gap, n_gap;
    logic [dsbd_pkg::NUM_W-1:0]      r_rem, n_rem;
    logic [dsbd_pkg::NUM_W-1:0]      r_acc, n_acc;
    logic [dsbd_pkg::QBITS_W-1:0]    r_q, n_q;
    logic [dsbd_pkg::STEP_W-1:0]     r_step, n_step;
    logic [dsbd_pkg::MONTH_W-1:0]    r_mo, n_mo;
    logic [dsbd_pkg::YEAR_W-1:0]     r_ry, n_ry;
    logic [dsbd_pkg::MONTH_W-1:0]    r_rm, n_rm;
    logic [dsbd_pkg::DAY_W-1:0]      r_rd, n_rd;
    logic [1:0]                      r_status, n_status;

    logic [dsbd_pkg::YEAR_W-1:0]     in_y;
    logic [dsbd_pkg::MONTH_W-1:0]    in_m;
    logic [dsbd_pkg::DAY_W-1:0]      in_d;
    logic [dsbd_pkg::GAP_W-1:0]      in_gap;
    logic [dsbd_pkg::NUM_W-1:0]      u_cmp, u_wgt;
    dsbd_pkg::t_unit_res             u_res;
    logic                            leap;
    logic [dsbd_pkg::DAY_W-1:0]      dim_start, dim_walk;
    logic [dsbd_pkg::NUM_W:0]        sum_fwd;
    logic [dsbd_pkg::NUM_W-1:0]      t_shift;
    logic                            fits;

    assign in_y   = i_s_tdata[13:0];
    assign in_m   = i_s_tdata[17:14];
    assign in_d   = i_s_tdata[22:18];
    assign in_gap = i_s_tdata[44:23];

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {1'b0, r_rd, r_rm, r_ry};
    assign o_m_tuser  = r_status;

    assign leap      = dsbd_pkg::leap_of(r_q);
    assign dim_start = dsbd_pkg::month_days(r_m, leap);
    assign dim_walk  = dsbd_pkg::month_days(r_mo, leap);

    always_comb begin
        case (r_state)
            S_NSTEP: begin
                u_cmp = dsbd_pkg::step_days(r_step);
                u_wgt = dsbd_pkg::step_years(r_step);
            end
            S_MWALK: begin
                u_cmp = {{(dsbd_pkg::NUM_W-dsbd_pkg::DAY_W){1'b0}}, dim_walk};
                u_wgt = '0;
            end
            default: begin
                u_cmp = dsbd_pkg::step_years(r_step);
                u_wgt = dsbd_pkg::step_days(r_step);
            end
        endcase
    end

    dsbd_unit u_unit (
        .i_rem (r_rem),
        .i_acc (r_acc),
        .i_cmp (u_cmp),
        .i_wgt (u_wgt),
        .o_res (u_res)
    );

    assign sum_fwd = {1'b0, r_acc} + {1'b0, r_gap};
    assign t_shift = r_back ? (r_acc - r_gap) : sum_fwd[dsbd_pkg::NUM_W-1:0];
    assign fits    = r_back ? (r_gap <= r_acc) : (sum_fwd < dsbd_pkg::TOTAL_DAYS);

    always_comb begin
        n_state  = r_state;
        n_back   = r_back;
        n_m      = r_m;
        n_d      = r_d;
        n_gap    = r_gap;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_q      = r_q;
        n_step   = r_step;
        n_mo     = r_mo;
        n_ry     = r_ry;
        n_rm     = r_rm;
        n_rd     = r_rd;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_back = i_s_tuser;
                    n_m    = in_m;
                    n_d    = in_d;
                    n_gap  = in_gap;
                    n_ry   = in_y;
                    n_rm   = in_m;
                    n_rd   = in_d;
                    n_rem  = {{(dsbd_pkg::NUM_W-dsbd_pkg::YEAR_W){1'b0}}, in_y - 14'd1};
                    n_acc  = '0;
                    n_q    = '0;
                    n_step = '0;
                    if (in_y == '0 || in_y > dsbd_pkg::MAX_YEAR || in_m == '0 ||
                        in_m > dsbd_pkg::LAST_MONTH || in_d == '0 ||
                        in_gap >= dsbd_pkg::GAP_LIMIT) begin
                        n_status = dsbd_pkg::ST_INVALID;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_YSTEP;
                    end
                end
            end
            S_YSTEP: begin
                n_rem  = u_res.rem;
                n_acc  = u_res.acc;
                n_q    = {r_q[dsbd_pkg::QBITS_W-2:0], u_res.ge};
                n_step = r_step + 4'd1;
                if (r_step == dsbd_pkg::LAST_STEP) begin
                    n_state = S_MDAY;
                end
            end
            S_MDAY: begin
                if (r_d > dim_start) begin
                    n_status = dsbd_pkg::ST_INVALID;
                    n_state  = S_OUT;
                end else if (r_gap == '0) begin
                    n_status = dsbd_pkg::ST_OK;
                    n_state  = S_OUT;
                end else begin
                    n_acc = r_acc
                          + {13'd0, dsbd_pkg::days_before_month(r_m)}
                          + {21'd0, (leap && r_m > 4'd2)}
                          + {17'd0, r_d}
                          - 22'd1;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!fits) begin
                    n_status = dsbd_pkg::ST_RANGE;
                    n_state  = S_OUT;
                end else begin
                    n_rem   = t_shift;
                    n_acc   = '0;
                    n_q     = '0;
                    n_step  = '0;
                    n_state = S_NSTEP;
                end
            end
            S_NSTEP: begin
                n_rem  = u_res.rem;
                n_acc  = u_res.acc;
                n_q    = {r_q[dsbd_pkg::QBITS_W-2:0], u_res.ge};
                n_step = r_step + 4'd1;
                if (r_step == dsbd_pkg::LAST_STEP) begin
                    n_ry    = u_res.acc[dsbd_pkg::YEAR_W-1:0] + 14'd1;
                    n_mo    = 4'd1;
                    n_state = S_MWALK;
                end
            end
            S_MWALK: begin
                if (r_mo < dsbd_pkg::LAST_MONTH && u_res.ge) begin
                    n_rem = u_res.rem;
                    n_mo  = r_mo + 4'd1;
                end else begin
                    n_rm     = r_mo;
                    n_rd     = r_rem[dsbd_pkg::DAY_W-1:0] + 5'd1;
                    n_status = dsbd_pkg::ST_OK;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_back   <= n_back;
        r_m      <= n_m;
        r_d      <= n_d;
        r_gap    <= n_gap;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_q      <= n_q;
        r_step   <= n_step;
        r_mo     <= n_mo;
        r_ry     <= n_ry;
        r_rm     <= n_rm;
        r_rd     <= n_rd;
        r_status <= n_status;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted again while an item is in flight");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YSTEP || r_state == S_NSTEP) |-> (r_step <= dsbd_pkg::LAST_STEP))
        else $error("division step counter overran");

    a_ok_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == dsbd_pkg::ST_OK) |->
        (r_ry != '0 && r_ry <= dsbd_pkg::MAX_YEAR && r_rm != '0 &&
         r_rm <= dsbd_pkg::LAST_MONTH && r_rd != '0))
        else $error("result date out of calendar range with status ok");

    a_walk_year_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MWALK) |-> (r_ry != '0 && r_ry <= dsbd_pkg::MAX_YEAR))
        else $error("month walk started with a year out of range");
`endif

endmodule
